### design/hss_pkg.sv
// Shared types and constants of the humidity sensor two-wire master.
package hss_pkg;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_DONE      = 5'd1,
    PH_RST_SETUP = 5'd2,
    PH_RST_HI    = 5'd3,
    PH_RST_LO    = 5'd4,
    PH_ST0       = 5'd5,
    PH_ST1       = 5'd6,
    PH_ST2       = 5'd7,
    PH_ST3       = 5'd8,
    PH_ST4       = 5'd9,
    PH_ST5       = 5'd10,
    PH_ST6       = 5'd11,
    PH_WR_LO     = 5'd12,
    PH_WR_HI     = 5'd13,
    PH_WR_REL    = 5'd14,
    PH_WR_ACK    = 5'd15,
    PH_WR_END    = 5'd16,
    PH_WAIT      = 5'd17,
    PH_BUSY      = 5'd18,
    PH_RD_REL    = 5'd19,
    PH_RD_HI     = 5'd20,
    PH_RD_LO     = 5'd21,
    PH_AK_SET    = 5'd22,
    PH_AK_HI     = 5'd23,
    PH_AK_END    = 5'd24
  } phase_t;

  localparam logic [2:0] JOB_TEMP         = 3'd0;
  localparam logic [2:0] JOB_HUMI         = 3'd1;
  localparam logic [2:0] JOB_READ_STATUS  = 3'd2;
  localparam logic [2:0] JOB_WRITE_STATUS = 3'd3;
  localparam logic [2:0] JOB_SOFT_RESET   = 3'd4;
  localparam logic [2:0] JOB_LINK_RESET   = 3'd5;

  localparam logic [2:0] CFG_TEMP_CMD     = 3'd0;
  localparam logic [2:0] CFG_HUMI_CMD     = 3'd1;
  localparam logic [2:0] CFG_STAT_RD_CMD  = 3'd2;
  localparam logic [2:0] CFG_STAT_WR_CMD  = 3'd3;
  localparam logic [2:0] CFG_RESET_CMD    = 3'd4;
  localparam logic [2:0] CFG_WAIT_TICKS   = 3'd5;

  // start condition pin levels, bit k is step k
  localparam logic [6:0] START_CLK = 7'b0110110;
  localparam logic [6:0] START_DAT = 7'b1100011;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [7:0]  temp_command;
    logic [7:0]  humi_command;
    logic [7:0]  status_read_command;
    logic [7:0]  status_write_command;
    logic [7:0]  reset_command;
    logic [15:0] wait_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  job;
    logic [3:0]  bit_count;
    logic [1:0]  byte_count;
    logic [7:0]  shift_byte;
    logic [15:0] value_reg;
    logic [7:0]  check_reg;
    logic [15:0] wait_count;
    logic [1:0]  errors;
  } state_t;

  typedef struct packed {
    logic        clock_out;
    logic        data_out;
    logic        drive_enable;
    logic        busy_res;
    logic        done_res;
    logic [15:0] measured_value;
    logic [7:0]  checksum;
    logic [1:0]  error_count;
  } result_t;

endpackage

### design/humidity_sensor_two_wire_master.sv
// Top level of the two-wire humidity sensor master.
// The result of an accepted tick is formed combinationally and registered in the output register.
// Throughput: one tick per cycle; the single output register refills as it drains.
// Input stalls only while the output register is full and the output is stalled.
// Reset (synchronous, active high): sequencer idle, counters and errors cleared,
// command registers and wait_ticks at their defaults, no result pending.
module humidity_sensor_two_wire_master #(
  parameter int unsigned RESET_CLOCKS = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic        start_req,
  input  logic        data_in,
  input  logic [7:0]  write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        clock_out,
  output logic        data_out,
  output logic        drive_enable,
  output logic        busy_res,
  output logic        done_res,
  output logic [15:0] measured_value,
  output logic [7:0]  checksum,
  output logic [1:0]  error_count
);

  hss_pkg::cfg_t    cfg;
  hss_pkg::result_t result;
  hss_pkg::result_t held;
  logic             accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  hss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hss_seq #(
    .RESET_CLOCKS (RESET_CLOCKS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .kind        (kind),
    .start_req   (start_req),
    .data_in     (data_in),
    .write_value (write_value),
    .cfg         (cfg),
    .result      (result)
  );

  hss_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .result    (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign clock_out      = held.clock_out;
  assign data_out       = held.data_out;
  assign drive_enable   = held.drive_enable;
  assign busy_res       = held.busy_res;
  assign done_res       = held.done_res;
  assign measured_value = held.measured_value;
  assign checksum       = held.checksum;
  assign error_count    = held.error_count;

endmodule

### design/hss_cfg.sv
// Configuration registers: command bytes and busy-check wait.
module hss_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output hss_pkg::cfg_t     cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_command         <= 8'd3;
      cfg.humi_command         <= 8'd5;
      cfg.status_read_command  <= 8'd7;
      cfg.status_write_command <= 8'd6;
      cfg.reset_command        <= 8'd30;
      cfg.wait_ticks           <= 16'd400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hss_pkg::CFG_TEMP_CMD:    cfg.temp_command         <= cfg_data[7:0];
        hss_pkg::CFG_HUMI_CMD:    cfg.humi_command         <= cfg_data[7:0];
        hss_pkg::CFG_STAT_RD_CMD: cfg.status_read_command  <= cfg_data[7:0];
        hss_pkg::CFG_STAT_WR_CMD: cfg.status_write_command <= cfg_data[7:0];
        hss_pkg::CFG_RESET_CMD:   cfg.reset_command        <= cfg_data[7:0];
        hss_pkg::CFG_WAIT_TICKS:  cfg.wait_ticks           <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/hss_seq.sv
// Job sequencer: state register and per-tick pin and status logic.
module hss_seq #(
  parameter int unsigned RESET_CLOCKS = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [2:0]        kind,
  input  logic              start_req,
  input  logic              data_in,
  input  logic [7:0]        write_value,
  input  hss_pkg::cfg_t     cfg,
  output hss_pkg::result_t  result
);

  hss_pkg::state_t st;
  hss_pkg::state_t st_next;

  logic       clk_lvl;
  logic       dat_lvl;
  logic       en_lvl;
  logic       busy_lvl;
  logic       done_lvl;
  logic [1:0] nbytes;
  logic       last_byte;
  logic [2:0] start_step;
  logic [3:0] bit_inc;
  logic [1:0] byte_inc;
  logic [15:0] wait_inc;
  logic [7:0] command;
  logic [1:0] err_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= hss_pkg::PH_IDLE;
      st.job        <= '0;
      st.bit_count  <= '0;
      st.byte_count <= '0;
      st.shift_byte <= '0;
      st.value_reg  <= '0;
      st.check_reg  <= '0;
      st.wait_count <= '0;
      st.errors     <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    clk_lvl  = 1'b0;
    dat_lvl  = 1'b1;
    en_lvl   = 1'b0;
    busy_lvl = 1'b1;
    done_lvl = 1'b0;

    if (st.phase == hss_pkg::PH_IDLE && start_req && kind <= hss_pkg::JOB_LINK_RESET) begin
      st_next.job        = kind;
      st_next.value_reg  = (kind == hss_pkg::JOB_WRITE_STATUS) ? {8'd0, write_value} : 16'd0;
      st_next.check_reg  = '0;
      st_next.errors     = '0;
      st_next.byte_count = '0;
      st_next.bit_count  = '0;
      st_next.wait_count = '0;
      st_next.phase      = (kind >= hss_pkg::JOB_SOFT_RESET) ? hss_pkg::PH_RST_SETUP
                                                              : hss_pkg::PH_ST0;
    end

    nbytes     = (st_next.job == hss_pkg::JOB_READ_STATUS) ? 2'd2 : 2'd3;
    last_byte  = ({1'b0, st_next.byte_count} + 3'd1) >= {1'b0, nbytes};
    start_step = 3'(st_next.phase - hss_pkg::PH_ST0);
    bit_inc    = st_next.bit_count + 4'd1;
    byte_inc   = st_next.byte_count + 2'd1;
    wait_inc   = st_next.wait_count + 16'd1;
    err_inc    = (st_next.errors != 2'd3) ? st_next.errors + 2'd1 : st_next.errors;

    case (st_next.job)
      hss_pkg::JOB_TEMP:         command = cfg.temp_command;
      hss_pkg::JOB_HUMI:         command = cfg.humi_command;
      hss_pkg::JOB_READ_STATUS:  command = cfg.status_read_command;
      hss_pkg::JOB_WRITE_STATUS: command = cfg.status_write_command;
      default:                   command = cfg.reset_command;
    endcase

    if (st_next.phase >= hss_pkg::PH_ST0 && st_next.phase <= hss_pkg::PH_ST6) begin
      clk_lvl = hss_pkg::START_CLK[start_step];
      dat_lvl = hss_pkg::START_DAT[start_step];
      en_lvl  = 1'b1;
      if (st_next.phase != hss_pkg::PH_ST6) begin
        st_next.phase = hss_pkg::phase_t'(st_next.phase + 5'd1);
      end else if (st_next.job == hss_pkg::JOB_LINK_RESET) begin
        st_next.phase = hss_pkg::PH_DONE;
      end else begin
        st_next.shift_byte = command;
        st_next.bit_count  = '0;
        st_next.phase      = hss_pkg::PH_WR_LO;
      end
    end else begin
      unique case (st_next.phase)
        hss_pkg::PH_IDLE: begin
          busy_lvl = 1'b0;
        end
        hss_pkg::PH_DONE: begin
          busy_lvl      = 1'b0;
          done_lvl      = 1'b1;
          st_next.phase = hss_pkg::PH_IDLE;
        end
        hss_pkg::PH_RST_SETUP: begin
          en_lvl            = 1'b1;
          st_next.bit_count = '0;
          st_next.phase     = hss_pkg::PH_RST_HI;
        end
        hss_pkg::PH_RST_HI: begin
          clk_lvl       = 1'b1;
          en_lvl        = 1'b1;
          st_next.phase = hss_pkg::PH_RST_LO;
        end
        hss_pkg::PH_RST_LO: begin
          en_lvl            = 1'b1;
          st_next.bit_count = bit_inc;
          st_next.phase     = (bit_inc >= 4'(RESET_CLOCKS)) ? hss_pkg::PH_ST0
                                                             : hss_pkg::PH_RST_HI;
        end
        hss_pkg::PH_WR_LO: begin
          dat_lvl       = st_next.shift_byte[7];
          en_lvl        = 1'b1;
          st_next.phase = hss_pkg::PH_WR_HI;
        end
        hss_pkg::PH_WR_HI: begin
          clk_lvl            = 1'b1;
          dat_lvl            = st_next.shift_byte[7];
          en_lvl             = 1'b1;
          st_next.shift_byte = {st_next.shift_byte[6:0], 1'b0};
          st_next.bit_count  = bit_inc;
          st_next.phase      = (bit_inc >= hss_pkg::BITS_PER_BYTE) ? hss_pkg::PH_WR_REL
                                                                   : hss_pkg::PH_WR_LO;
        end
        hss_pkg::PH_WR_REL: begin
          st_next.phase = hss_pkg::PH_WR_ACK;
        end
        hss_pkg::PH_WR_ACK: begin
          clk_lvl = 1'b1;
          if (data_in) begin
            st_next.errors = err_inc;
          end
          st_next.phase = hss_pkg::PH_WR_END;
        end
        hss_pkg::PH_WR_END: begin
          if (st_next.job <= hss_pkg::JOB_HUMI) begin
            st_next.wait_count = '0;
            st_next.phase      = (cfg.wait_ticks == 16'd0) ? hss_pkg::PH_BUSY
                                                           : hss_pkg::PH_WAIT;
          end else if (st_next.job == hss_pkg::JOB_READ_STATUS) begin
            st_next.byte_count = '0;
            st_next.phase      = hss_pkg::PH_RD_REL;
          end else if (st_next.job == hss_pkg::JOB_WRITE_STATUS &&
                       st_next.byte_count == 2'd0) begin
            st_next.byte_count = 2'd1;
            st_next.shift_byte = st_next.value_reg[7:0];
            st_next.bit_count  = '0;
            st_next.phase      = hss_pkg::PH_WR_LO;
          end else begin
            st_next.phase = hss_pkg::PH_DONE;
          end
        end
        hss_pkg::PH_WAIT: begin
          st_next.wait_count = wait_inc;
          if (wait_inc >= cfg.wait_ticks) begin
            st_next.phase = hss_pkg::PH_BUSY;
          end
        end
        hss_pkg::PH_BUSY: begin
          if (data_in) begin
            st_next.errors = err_inc;
          end
          st_next.byte_count = '0;
          st_next.phase      = hss_pkg::PH_RD_REL;
        end
        hss_pkg::PH_RD_REL: begin
          st_next.bit_count  = '0;
          st_next.shift_byte = '0;
          st_next.phase      = hss_pkg::PH_RD_HI;
        end
        hss_pkg::PH_RD_HI: begin
          clk_lvl            = 1'b1;
          st_next.shift_byte = {st_next.shift_byte[6:0], data_in};
          st_next.phase      = hss_pkg::PH_RD_LO;
        end
        hss_pkg::PH_RD_LO: begin
          st_next.bit_count = bit_inc;
          if (bit_inc >= hss_pkg::BITS_PER_BYTE) begin
            if (last_byte) begin
              st_next.check_reg = st_next.shift_byte;
            end else if (st_next.job == hss_pkg::JOB_READ_STATUS) begin
              st_next.value_reg = {8'd0, st_next.shift_byte};
            end else if (st_next.byte_count == 2'd0) begin
              st_next.value_reg = {st_next.shift_byte, st_next.value_reg[7:0]};
            end else begin
              st_next.value_reg = {st_next.value_reg[15:8], st_next.shift_byte};
            end
            st_next.phase = hss_pkg::PH_AK_SET;
          end else begin
            st_next.phase = hss_pkg::PH_RD_HI;
          end
        end
        hss_pkg::PH_AK_SET, hss_pkg::PH_AK_HI: begin
          dat_lvl       = last_byte;
          en_lvl        = 1'b1;
          clk_lvl       = (st_next.phase == hss_pkg::PH_AK_HI);
          st_next.phase = hss_pkg::phase_t'(st_next.phase + 5'd1);
        end
        hss_pkg::PH_AK_END: begin
          en_lvl             = 1'b1;
          st_next.byte_count = byte_inc;
          st_next.phase      = (byte_inc >= nbytes) ? hss_pkg::PH_DONE : hss_pkg::PH_RD_REL;
        end
        default: begin
          busy_lvl      = 1'b0;
          st_next.phase = hss_pkg::PH_IDLE;
        end
      endcase
    end

    result.clock_out      = clk_lvl;
    result.data_out       = dat_lvl;
    result.drive_enable   = en_lvl;
    result.busy_res       = busy_lvl;
    result.done_res       = done_lvl;
    result.measured_value = st_next.value_reg;
    result.checksum       = st_next.check_reg;
    result.error_count    = st_next.errors;
  end

endmodule

### design/hss_out_reg.sv
// Result register between the sequencer and the output channel.
module hss_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hss_pkg::result_t  result,
  output logic              out_valid,
  input  logic              out_stall,
  output hss_pkg::result_t  held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

### bench/tb_humidity_sensor_two_wire_master.sv
// Self-checking bench for the two-wire humidity sensor master: pin ticks against a local model.
`timescale 1ns / 1ps

module tb_humidity_sensor_two_wire_master;

  localparam int RST_CLOCKS = 9;
  localparam int LIMIT = 1000000;
  localparam int ROWS = 17;
  localparam int PHASE_TICKS = 20;

  localparam logic [6:0] SCL_START = 7'b0110110;
  localparam logic [6:0] SDA_START = 7'b1100011;

  localparam hss_pkg::result_t PINS_IDLE = '{clock_out: 1'b0, data_out: 1'b1,
                                             drive_enable: 1'b0, busy_res: 1'b0,
                                             done_res: 1'b0, measured_value: 16'h0000,
                                             checksum: 8'h00, error_count: 2'd0};

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  wval;
    logic [23:0] reply;
    logic [1:0]  acks;
    logic        busy;
    logic        wset;
    logic [15:0] wait_new;
    logic        mset;
    logic [15:0] wait_mid;
    logic        chatter;
    logic        typed;
    logic [15:0] val;
    logic [7:0]  chk;
    logic [1:0]  err;
  } job_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = 3'd0;
  logic        start_req = 1'b0;
  logic        data_in = 1'b0;
  logic [7:0]  write_value = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        clock_out;
  logic        data_out;
  logic        drive_enable;
  logic        busy_res;
  logic        done_res;
  logic [15:0] measured_value;
  logic [7:0]  checksum;
  logic [1:0]  error_count;

  hss_pkg::cfg_t    regs = '{8'd3, 8'd5, 8'd7, 8'd6, 8'd30, 16'd400};
  hss_pkg::state_t  st = '0;
  hss_pkg::result_t pins_due [$];
  hss_pkg::result_t want_r, got_r;
  job_row_t         job_table [0:ROWS-1];

  logic [23:0] plan_reply = 24'h0;
  logic [1:0]  plan_acks = 2'b00;
  logic        plan_busy = 1'b0;
  logic        plan_wild = 1'b0;

  bit          typed_on = 1'b0;
  logic [15:0] typed_val;
  logic [7:0]  typed_chk;
  logic [1:0]  typed_err;

  int send_idle = 0;
  int recv_stall = 0;
  int failures = 0;
  int tick_count = 0;
  int cycles = 0;

  humidity_sensor_two_wire_master #(.RESET_CLOCKS(RST_CLOCKS)) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .start_req      (start_req),
    .data_in        (data_in),
    .write_value    (write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .clock_out      (clock_out),
    .data_out       (data_out),
    .drive_enable   (drive_enable),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .measured_value (measured_value),
    .checksum       (checksum),
    .error_count    (error_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] command_byte(input logic [2:0] j);
    case (j)
      hss_pkg::JOB_TEMP:         return regs.temp_command;
      hss_pkg::JOB_HUMI:         return regs.humi_command;
      hss_pkg::JOB_READ_STATUS:  return regs.status_read_command;
      hss_pkg::JOB_WRITE_STATUS: return regs.status_write_command;
      default:                   return regs.reset_command;
    endcase
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    st.shift_byte = b;
    st.bit_count = 4'd0;
    st.phase = hss_pkg::PH_WR_LO;
  endfunction

  function automatic hss_pkg::result_t pins_for_tick(input logic [2:0] k, input logic req,
                                                     input logic din, input logic [7:0] wv);
    hss_pkg::result_t r;
    int nbytes;
    int ofs;
    r = PINS_IDLE;
    r.busy_res = 1'b1;
    if (st.phase == hss_pkg::PH_IDLE && req && k <= hss_pkg::JOB_LINK_RESET) begin
      st.job = k;
      st.value_reg = (k == hss_pkg::JOB_WRITE_STATUS) ? {8'h00, wv} : 16'h0000;
      st.check_reg = 8'h00;
      st.errors = 2'd0;
      st.byte_count = 2'd0;
      st.bit_count = 4'd0;
      st.wait_count = 16'd0;
      st.phase = (k >= hss_pkg::JOB_SOFT_RESET) ? hss_pkg::PH_RST_SETUP : hss_pkg::PH_ST0;
    end
    nbytes = (st.job == hss_pkg::JOB_READ_STATUS) ? 2 : 3;
    if (st.phase >= hss_pkg::PH_ST0 && st.phase <= hss_pkg::PH_ST6) begin
      ofs = int'(st.phase) - int'(hss_pkg::PH_ST0);
      r.clock_out = SCL_START[ofs];
      r.data_out = SDA_START[ofs];
      r.drive_enable = 1'b1;
      if (st.phase < hss_pkg::PH_ST6) st.phase = hss_pkg::phase_t'(st.phase + 5'd1);
      else if (st.job == hss_pkg::JOB_LINK_RESET) st.phase = hss_pkg::PH_DONE;
      else load_byte(command_byte(st.job));
    end else begin
      case (st.phase)
        hss_pkg::PH_IDLE: r.busy_res = 1'b0;
        hss_pkg::PH_DONE: begin
          r.busy_res = 1'b0;
          r.done_res = 1'b1;
          st.phase = hss_pkg::PH_IDLE;
        end
        hss_pkg::PH_RST_SETUP: begin
          r.drive_enable = 1'b1;
          st.bit_count = 4'd0;
          st.phase = hss_pkg::PH_RST_HI;
        end
        hss_pkg::PH_RST_HI: begin
          r.clock_out = 1'b1;
          r.drive_enable = 1'b1;
          st.phase = hss_pkg::PH_RST_LO;
        end
        hss_pkg::PH_RST_LO: begin
          r.drive_enable = 1'b1;
          st.bit_count = st.bit_count + 4'd1;
          st.phase = (int'(st.bit_count) >= RST_CLOCKS) ? hss_pkg::PH_ST0 : hss_pkg::PH_RST_HI;
        end
        hss_pkg::PH_WR_LO: begin
          r.data_out = st.shift_byte[7];
          r.drive_enable = 1'b1;
          st.phase = hss_pkg::PH_WR_HI;
        end
        hss_pkg::PH_WR_HI: begin
          r.clock_out = 1'b1;
          r.data_out = st.shift_byte[7];
          r.drive_enable = 1'b1;
          st.shift_byte = {st.shift_byte[6:0], 1'b0};
          st.bit_count = st.bit_count + 4'd1;
          st.phase = (st.bit_count >= 4'd8) ? hss_pkg::PH_WR_REL : hss_pkg::PH_WR_LO;
        end
        hss_pkg::PH_WR_REL: st.phase = hss_pkg::PH_WR_ACK;
        hss_pkg::PH_WR_ACK: begin
          r.clock_out = 1'b1;
          if (din && st.errors != 2'd3) st.errors = st.errors + 2'd1;
          st.phase = hss_pkg::PH_WR_END;
        end
        hss_pkg::PH_WR_END: begin
          if (st.job <= hss_pkg::JOB_HUMI) begin
            st.wait_count = 16'd0;
            st.phase = (regs.wait_ticks == 16'd0) ? hss_pkg::PH_BUSY : hss_pkg::PH_WAIT;
          end else if (st.job == hss_pkg::JOB_READ_STATUS) begin
            st.byte_count = 2'd0;
            st.phase = hss_pkg::PH_RD_REL;
          end else if (st.job == hss_pkg::JOB_WRITE_STATUS && st.byte_count == 2'd0) begin
            st.byte_count = 2'd1;
            load_byte(st.value_reg[7:0]);
          end else begin
            st.phase = hss_pkg::PH_DONE;
          end
        end
        hss_pkg::PH_WAIT: begin
          st.wait_count = st.wait_count + 16'd1;
          if (st.wait_count >= regs.wait_ticks) st.phase = hss_pkg::PH_BUSY;
        end
        hss_pkg::PH_BUSY: begin
          if (din && st.errors != 2'd3) st.errors = st.errors + 2'd1;
          st.byte_count = 2'd0;
          st.phase = hss_pkg::PH_RD_REL;
        end
        hss_pkg::PH_RD_REL: begin
          st.bit_count = 4'd0;
          st.shift_byte = 8'h00;
          st.phase = hss_pkg::PH_RD_HI;
        end
        hss_pkg::PH_RD_HI: begin
          r.clock_out = 1'b1;
          st.shift_byte = {st.shift_byte[6:0], din};
          st.phase = hss_pkg::PH_RD_LO;
        end
        hss_pkg::PH_RD_LO: begin
          st.bit_count = st.bit_count + 4'd1;
          if (st.bit_count >= 4'd8) begin
            if (int'(st.byte_count) + 1 >= nbytes) st.check_reg = st.shift_byte;
            else if (st.job == hss_pkg::JOB_READ_STATUS) st.value_reg = {8'h00, st.shift_byte};
            else if (st.byte_count == 2'd0) st.value_reg = {st.shift_byte, st.value_reg[7:0]};
            else st.value_reg[7:0] = st.shift_byte;
            st.phase = hss_pkg::PH_AK_SET;
          end else begin
            st.phase = hss_pkg::PH_RD_HI;
          end
        end
        hss_pkg::PH_AK_SET, hss_pkg::PH_AK_HI: begin
          r.data_out = (int'(st.byte_count) + 1 >= nbytes);
          r.drive_enable = 1'b1;
          r.clock_out = (st.phase == hss_pkg::PH_AK_HI);
          st.phase = hss_pkg::phase_t'(st.phase + 5'd1);
        end
        hss_pkg::PH_AK_END: begin
          r.drive_enable = 1'b1;
          st.byte_count = st.byte_count + 2'd1;
          st.phase = (int'(st.byte_count) >= nbytes) ? hss_pkg::PH_DONE : hss_pkg::PH_RD_REL;
        end
        default: begin
          r.busy_res = 1'b0;
          st.phase = hss_pkg::PH_IDLE;
        end
      endcase
    end
    r.measured_value = st.value_reg;
    r.checksum = st.check_reg;
    r.error_count = st.errors;
    return r;
  endfunction

  // answer as the sensor would on the ticks where the master samples the pin, or at random when plan_wild is set
  function automatic logic sensor_pin();
    if (plan_wild) return 1'($urandom);
    case (st.phase)
      hss_pkg::PH_WR_ACK: return plan_acks[st.byte_count[0]];
      hss_pkg::PH_BUSY:   return plan_busy;
      hss_pkg::PH_RD_HI:  return plan_reply[23 - 8 * int'(st.byte_count) - int'(st.bit_count)];
      default:            return 1'($urandom);
    endcase
  endfunction

  task automatic do_tick(input logic [2:0] k, input logic req, input logic din,
                         input logic [7:0] wv);
    hss_pkg::result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    start_req <= req;
    data_in <= din;
    write_value <= wv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = pins_for_tick(k, req, din, wv);
    if (typed_on && r.done_res) begin
      r.measured_value = typed_val;
      r.checksum = typed_chk;
      r.error_count = typed_err;
      typed_on = 1'b0;
    end
    pins_due.push_back(r);
    tick_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pins_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] d, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hss_pkg::CFG_TEMP_CMD:    regs.temp_command = d[7:0];
      hss_pkg::CFG_HUMI_CMD:    regs.humi_command = d[7:0];
      hss_pkg::CFG_STAT_RD_CMD: regs.status_read_command = d[7:0];
      hss_pkg::CFG_STAT_WR_CMD: regs.status_write_command = d[7:0];
      hss_pkg::CFG_RESET_CMD:   regs.reset_command = d[7:0];
      hss_pkg::CFG_WAIT_TICKS:  regs.wait_ticks = d;
      default: ;
    endcase
    @(negedge clk);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [7:0] c_t, input logic [7:0] c_h, input logic [7:0] c_sr,
                           input logic [7:0] c_sw, input logic [7:0] c_rs,
                           input logic [15:0] w);
    cfg_write(hss_pkg::CFG_TEMP_CMD, {8'($urandom), c_t}, 1'b1);
    cfg_write(hss_pkg::CFG_HUMI_CMD, {8'($urandom), c_h}, 1'b1);
    cfg_write(hss_pkg::CFG_STAT_RD_CMD, {8'($urandom), c_sr}, 1'b1);
    cfg_write(hss_pkg::CFG_STAT_WR_CMD, {8'($urandom), c_sw}, 1'b1);
    cfg_write(hss_pkg::CFG_RESET_CMD, {8'($urandom), c_rs}, 1'b1);
    cfg_write(hss_pkg::CFG_WAIT_TICKS, w, 1'b1);
    cfg_write(hss_pkg::CFG_WAIT_TICKS + 3'($urandom_range(1, 2)), 16'($urandom), 1'b0);
  endtask

  task automatic run_job(input logic [2:0] k, input logic [7:0] wv, input bit chatter,
                         input bit mset, input logic [15:0] mid);
    bit mid_done;
    bit req;
    mid_done = 1'b0;
    do_tick(k, 1'b1, sensor_pin(), wv);
    while (st.phase != hss_pkg::PH_IDLE) begin
      if (mset && !mid_done && st.phase == hss_pkg::PH_WAIT && st.wait_count == 16'd2) begin
        drain();
        cfg_write(hss_pkg::CFG_WAIT_TICKS, mid, 1'b0);
        mid_done = 1'b1;
      end
      // pester the master while busy and on the finish tick
      req = chatter && (st.phase == hss_pkg::PH_DONE || $urandom_range(3) == 0);
      do_tick(req ? 3'($urandom) : k, req, sensor_pin(), 8'($urandom));
    end
  endtask

  task automatic field_check(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_r = '{clock_out, data_out, drive_enable, busy_res, done_res,
                measured_value, checksum, error_count};
      if (pins_due.size() == 0) begin
        $display("%0t ns: result with none expected, actual %h", $time, got_r);
        failures++;
      end else begin
        want_r = pins_due.pop_front();
        field_check("clock_out", want_r.clock_out, got_r.clock_out);
        field_check("data_out", want_r.data_out, got_r.data_out);
        field_check("drive_enable", want_r.drive_enable, got_r.drive_enable);
        field_check("busy_res", want_r.busy_res, got_r.busy_res);
        field_check("done_res", want_r.done_res, got_r.done_res);
        field_check("measured_value", want_r.measured_value, got_r.measured_value);
        field_check("checksum", want_r.checksum, got_r.checksum);
        field_check("error_count", want_r.error_count, got_r.error_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int i;
    int ph;
    int mark;
    job_row_t row;
    logic [2:0] k;

    job_table[0]  = '{hss_pkg::JOB_TEMP, 8'h00, 24'hABCDEF, 2'b00, 1'b0, 1'b0, 16'd0, 1'b1,
                      16'd5, 1'b0, 1'b1, 16'hABCD, 8'hEF, 2'd0};
    job_table[1]  = '{hss_pkg::JOB_HUMI, 8'h00, 24'hFFFFFF, 2'b00, 1'b1, 1'b1, 16'd0, 1'b0,
                      16'd0, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 2'd1};
    job_table[2]  = '{hss_pkg::JOB_READ_STATUS, 8'h00, 24'h805A00, 2'b01, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b0, 1'b1, 16'h0080, 8'h5A, 2'd1};
    job_table[3]  = '{hss_pkg::JOB_WRITE_STATUS, 8'hFF, 24'h000000, 2'b11, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b0, 1'b1, 16'h00FF, 8'h00, 2'd2};
    job_table[4]  = '{hss_pkg::JOB_WRITE_STATUS, 8'h00, 24'hFFFFFF, 2'b00, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b0, 1'b1, 16'h0000, 8'h00, 2'd0};
    job_table[5]  = '{hss_pkg::JOB_SOFT_RESET, 8'h00, 24'h000000, 2'b01, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b0, 1'b1, 16'h0000, 8'h00, 2'd1};
    job_table[6]  = '{hss_pkg::JOB_LINK_RESET, 8'h00, 24'h000000, 2'b00, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b0, 1'b1, 16'h0000, 8'h00, 2'd0};
    job_table[7]  = '{3'd6, 8'h00, 24'h000000, 2'b00, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0,
                      1'b0, 1'b0, 16'h0000, 8'h00, 2'd0};
    job_table[8]  = '{3'd7, 8'hFF, 24'h000000, 2'b00, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0,
                      1'b0, 1'b0, 16'h0000, 8'h00, 2'd0};
    job_table[9]  = '{hss_pkg::JOB_TEMP, 8'h00, 24'h000000, 2'b00, 1'b0, 1'b1, 16'hFFFF, 1'b1,
                      16'd3, 1'b0, 1'b1, 16'h0000, 8'h00, 2'd0};
    job_table[10] = '{hss_pkg::JOB_HUMI, 8'h00, 24'h123456, 2'b00, 1'b0, 1'b1, 16'd10, 1'b1,
                      16'd1, 1'b1, 1'b1, 16'h1234, 8'h56, 2'd0};
    job_table[11] = '{hss_pkg::JOB_TEMP, 8'h00, 24'h010203, 2'b00, 1'b0, 1'b1, 16'd3, 1'b1,
                      16'd20, 1'b0, 1'b1, 16'h0102, 8'h03, 2'd0};
    job_table[12] = '{hss_pkg::JOB_TEMP, 8'h00, 24'h7E81C3, 2'b01, 1'b1, 1'b0, 16'd0, 1'b0,
                      16'd0, 1'b1, 1'b1, 16'h7E81, 8'hC3, 2'd2};
    job_table[13] = '{hss_pkg::JOB_READ_STATUS, 8'h00, 24'hFF0000, 2'b00, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b1, 1'b1, 16'h00FF, 8'h00, 2'd0};
    job_table[14] = '{hss_pkg::JOB_SOFT_RESET, 8'h00, 24'h000000, 2'b00, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b1, 1'b1, 16'h0000, 8'h00, 2'd0};
    job_table[15] = '{hss_pkg::JOB_LINK_RESET, 8'h00, 24'h000000, 2'b00, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b1, 1'b1, 16'h0000, 8'h00, 2'd0};
    job_table[16] = '{hss_pkg::JOB_WRITE_STATUS, 8'hA5, 24'h000000, 2'b10, 1'b0, 1'b0, 16'd0,
                      1'b0, 16'd0, 1'b1, 1'b1, 16'h00A5, 8'h00, 2'd1};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first tick out of reset: idle pins, nothing latched
    do_tick(hss_pkg::JOB_TEMP, 1'b0, 1'b0, 8'h00);
    want_r = pins_due.pop_back();
    pins_due.push_back(PINS_IDLE);

    for (i = 0; i < ROWS; i++) begin
      row = job_table[i];
      if (row.wset) begin
        drain();
        cfg_write(hss_pkg::CFG_WAIT_TICKS, row.wait_new, 1'b0);
      end
      plan_reply = row.reply;
      plan_acks = row.acks;
      plan_busy = row.busy;
      plan_wild = 1'b0;
      typed_on = row.typed;
      typed_val = row.val;
      typed_chk = row.chk;
      typed_err = row.err;
      run_job(row.kind, row.wval, row.chatter, row.mset, row.wait_mid);
    end
    typed_on = 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          send_idle = 0;
          recv_stall = 0;
          load_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0);
        end
        1: begin
          send_idle = 88;
          recv_stall = 0;
          load_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'($urandom_range(1, 6)));
        end
        2: begin
          send_idle = 0;
          recv_stall = 88;
          load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom_range(0, 6)));
        end
        default: begin
          send_idle = 26;
          recv_stall = 26;
          load_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom_range(0, 6)));
        end
      endcase
      mark = tick_count;
      while (tick_count - mark < PHASE_TICKS) begin
        plan_reply = 24'($urandom);
        plan_acks = ($urandom_range(99) < 15) ? 2'($urandom) : 2'b00;
        plan_busy = ($urandom_range(9) == 0);
        plan_wild = ($urandom_range(9) == 0);
        k = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
        run_job(k, 8'($urandom), $urandom_range(3) == 0, 1'b0, 16'd0);
        repeat ($urandom_range(3)) do_tick(3'($urandom), 1'b0, 1'($urandom), 8'($urandom));
      end
    end

    drain();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
